// ----- sv/sliding_window_kth_smallest_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rank-order filter
// Clocked implication checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_KTH_SMALLEST_MACROS_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_MACROS_SVH

// same-cycle implication
`define SWKS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWKS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/swks_pkg.sv -----
// ----------------------------------------------------------------------------
// swks_pkg
// Shared types and constants of the sliding window rank-order filter.
// ----------------------------------------------------------------------------
package swks_pkg;

    localparam int CFG_BITS       = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANK       = 1'b1;

    typedef struct packed {
        logic step;
        logic remove_en;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- sv/swks_cell.sv -----
// ----------------------------------------------------------------------------
// swks_cell
// One slot of the sorted window (value, age, valid bit). Per beat it drops the
// oldest entry if enabled, inserts the sample in order, shifts with neighbors.
// ----------------------------------------------------------------------------
module swks_cell
    import swks_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [AW-1:0]          old_age,
    input  logic [SAMPLE_BITS-1:0] prev_value,
    input  logic [AW-1:0]          prev_age,
    input  logic                   prev_valid,
    input  logic                   prev_gt,
    input  logic                   prev_del,
    input  logic [SAMPLE_BITS-1:0] next_value,
    input  logic [AW-1:0]          next_age,
    input  logic                   next_valid,
    input  logic                   next_gt,
    output logic [SAMPLE_BITS-1:0] value,
    output logic [AW-1:0]          age,
    output logic                   valid,
    output logic                   gt,
    output logic                   del
);

    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic [AW-1:0]          age_reg, age_next;
    logic                   valid_reg, valid_next;

    logic                   rm;
    logic [SAMPLE_BITS-1:0] u_value, p_value;
    logic [AW-1:0]          u_age, p_age;
    logic                   u_valid, p_valid, u_gt, p_gt;

    always_comb
    begin
        gt  = !valid_reg || (value_reg > sample);
        rm  = ctrl.remove_en && valid_reg && (age_reg == old_age);
        del = prev_del || rm;

        // window after removal, at this slot and at the left slot
        u_value = del ? next_value : value_reg;
        u_age   = del ? next_age   : age_reg;
        u_valid = del ? next_valid : valid_reg;
        u_gt    = del ? next_gt    : gt;

        p_value = prev_del ? value_reg : prev_value;
        p_age   = prev_del ? age_reg   : prev_age;
        p_valid = prev_del ? valid_reg : prev_valid;
        p_gt    = prev_del ? gt        : prev_gt;

        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;

        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (p_gt)
            begin
                value_next = p_value;
                age_next   = p_age + 1'b1;
                valid_next = p_valid;
            end
            else if (u_gt)
            begin
                value_next = sample;
                age_next   = '0;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = u_value;
                age_next   = u_age + 1'b1;
                valid_next = u_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign valid = valid_reg;

endmodule

// ----- sv/swks_select.sv -----
// ----------------------------------------------------------------------------
// swks_select
// Output register: picks the ranked slot of the window and holds the result
// beat until the receiver takes it.
// ----------------------------------------------------------------------------
module swks_select
    import swks_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 4
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]  values,
    input  logic [AW-1:0]                           sel_idx,
    input  logic                                    load,
    input  logic                                    out_stall,
    output logic                                    out_valid,
    output logic [SAMPLE_BITS-1:0]                  selected_value
);

    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] data_reg, data_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            data_next      = values[sel_idx];
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid      = out_valid_reg;
    assign selected_value = data_reg;

endmodule

// ----- sv/sliding_window_kth_smallest.sv -----
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest
// Running rank-order filter: keeps the last window_len samples sorted and
// emits the rank-th smallest of each full window.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/sample: one sample per beat.
// Output channel out_valid/out_stall/selected_value: one result per sample
// once the window holds window_len samples; nothing while it fills.
// Configuration: cfg_we with cfg_index 0 writes window_len (empties the
// window), index 1 writes rank. Write only while the block is idle.
// Result path: the input beat updates the cell row, then the output register
// loads the result through the rank select mux.
// Throughput: 1 sample per cycle while in_stall is low; the cell row inserts
// and removes in the same cycle as the beat is taken.
// Receiver stall: one result is held in the output register and one more is
// pending in the cell row; in_stall rises only while both are occupied.
// Reset: window empty, window_len = 16, rank = 1, no result pending.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest
    import swks_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_BITS-1:0]    selected_value
);

`include "sliding_window_kth_smallest_macros.svh"

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [CFG_BITS-1:0] wl_reg, wl_next;
    logic [CFG_BITS-1:0] rank_reg, rank_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic                pend_reg, pend_next;

    logic [31:0]   wl_ext, rank_ext, w_eff32, r_eff32;
    logic [CW-1:0] w_eff;
    logic [AW-1:0] old_age, sel_idx;
    logic          accept, full, emit, load, wl_write;
    cell_ctrl_t    ctrl;

    logic [SAMPLE_BITS-1:0]                 cell_value [MAX_WINDOW];
    logic [AW-1:0]                          cell_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]                  cell_valid;
    logic [MAX_WINDOW-1:0]                  cell_gt;
    logic [MAX_WINDOW-1:0]                  cell_del;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] values;

    always_comb
    begin
        wl_ext   = {{(32-CFG_BITS){1'b0}}, wl_reg};
        rank_ext = {{(32-CFG_BITS){1'b0}}, rank_reg};
        if (wl_ext == 32'd0)
            w_eff32 = 32'd1;
        else if (wl_ext > 32'(MAX_WINDOW))
            w_eff32 = 32'(MAX_WINDOW);
        else
            w_eff32 = wl_ext;
        if (rank_ext == 32'd0)
            r_eff32 = 32'd1;
        else if (rank_ext > w_eff32)
            r_eff32 = w_eff32;
        else
            r_eff32 = rank_ext;
        w_eff   = w_eff32[CW-1:0];
        old_age = AW'(w_eff32 - 32'd1);
        sel_idx = AW'(r_eff32 - 32'd1);
    end

    assign in_stall = pend_reg && out_valid && out_stall;
    assign accept   = in_valid && !in_stall;
    assign load     = pend_reg && !(out_valid && out_stall);
    assign full     = (fill_reg >= w_eff);
    assign wl_write = cfg_we && (cfg_index == CFG_WINDOW_LEN);

    always_comb
    begin
        wl_next   = wl_reg;
        rank_next = rank_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LEN: wl_next   = cfg_wdata;
                CFG_RANK:       rank_next = cfg_wdata;
                default:        ;
            endcase
        end

        ctrl.step      = accept;
        ctrl.remove_en = full;
        ctrl.clear     = wl_write;

        fill_next = fill_reg;
        if (wl_write)
            fill_next = '0;
        else if (accept && !full)
            fill_next = fill_reg + 1'b1;

        emit = (fill_next == w_eff);

        pend_next = pend_reg;
        if (wl_write)
            pend_next = 1'b0;
        else if (accept)
            pend_next = emit;
        else if (load)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= CFG_BITS'(16);
            rank_reg <= CFG_BITS'(1);
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            wl_reg   <= wl_next;
            rank_reg <= rank_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] pv, nv;
        logic [AW-1:0]          pa, na;
        logic                   pval, pgt, pdel, nval, ngt;

        if (i == 0)
        begin : g_first
            assign pv   = '0;
            assign pa   = '0;
            assign pval = 1'b0;
            assign pgt  = 1'b0;
            assign pdel = 1'b0;
        end
        else
        begin : g_mid
            assign pv   = cell_value[i-1];
            assign pa   = cell_age[i-1];
            assign pval = cell_valid[i-1];
            assign pgt  = cell_gt[i-1];
            assign pdel = cell_del[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign nv   = '0;
            assign na   = '0;
            assign nval = 1'b0;
            assign ngt  = 1'b1;
        end
        else
        begin : g_inner
            assign nv   = cell_value[i+1];
            assign na   = cell_age[i+1];
            assign nval = cell_valid[i+1];
            assign ngt  = cell_gt[i+1];
        end

        swks_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AW          (AW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (sample),
            .old_age    (old_age),
            .prev_value (pv),
            .prev_age   (pa),
            .prev_valid (pval),
            .prev_gt    (pgt),
            .prev_del   (pdel),
            .next_value (nv),
            .next_age   (na),
            .next_valid (nval),
            .next_gt    (ngt),
            .value      (cell_value[i]),
            .age        (cell_age[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i]),
            .del        (cell_del[i])
        );

        assign values[i] = cell_value[i];
    end

    swks_select #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .values         (values),
        .sel_idx        (sel_idx),
        .load           (load),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .selected_value (selected_value)
    );

    `SWKS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= w_eff, "fill above window")
    `SWKS_ASSERT_IMP(a_fill_cells, clk, rst_n, 1'b1,
        $countones(cell_valid) == 32'(fill_reg), "valid cells differ from fill count")
    `SWKS_ASSERT_NXT(a_emit_pend, clk, rst_n, accept && emit && !wl_write, pend_reg,
        "result of full window not pending")
    `SWKS_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, pend_reg && out_valid,
        "input stalled without a held result")

endmodule
